@@ rtl/core/palette_led_strip_encoder_macros.svh @@
// Assertion macros used by the palette LED strip encoder checker.
`ifndef PALETTE_LED_STRIP_ENCODER_MACROS_SVH
`define PALETTE_LED_STRIP_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ple_pkg.sv @@
// Shared types and constants for the palette LED strip encoder.
package ple_pkg;

    localparam int WORD_W = 24;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 5;

    localparam logic [1:0] FUNC_SET  = 2'd0;
    localparam logic [1:0] FUNC_FILL = 2'd1;
    localparam logic [1:0] FUNC_SEND = 2'd2;

    localparam logic [2:0] CFG_ONE_PATTERN  = 3'd0;
    localparam logic [2:0] CFG_ZERO_PATTERN = 3'd1;
    localparam logic [2:0] CFG_PALETTE_0    = 3'd2;
    localparam logic [2:0] CFG_PALETTE_1    = 3'd3;
    localparam logic [2:0] CFG_PALETTE_2    = 3'd4;
    localparam logic [2:0] CFG_PALETTE_3    = 3'd5;

    localparam logic [WORD_W-1:0] PALETTE_0_RST = 24'h000000;
    localparam logic [WORD_W-1:0] PALETTE_1_RST = 24'hFF0000;
    localparam logic [WORD_W-1:0] PALETTE_2_RST = 24'h0000FF;
    localparam logic [WORD_W-1:0] PALETTE_3_RST = 24'h00FF00;

    localparam logic [BYTE_W-1:0] CODE_MASK = 8'h03;
    localparam logic [CNT_W-1:0]  BIT_LAST  = 5'd23;

    typedef struct packed {
        logic              load;
        logic [WORD_W-1:0] word;
        logic              last_led;
    } ser_load_t;

endpackage

@@ rtl/core/ple_store.sv @@
// Packed color code memory, one byte holds four LED codes.
module ple_store
    import ple_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/ple_serializer.sv @@
// Shift unit that turns one 24-bit GRB word into 24 SPI code bytes.
module ple_serializer
    import ple_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ser_load_t         load_in,
    input  logic [BYTE_W-1:0] one_pattern,
    input  logic [BYTE_W-1:0] zero_pattern,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [BYTE_W-1:0] code_byte,
    output logic              last_of_led,
    output logic              frame_done,
    output logic              busy
);

    logic              active_reg, active_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              last_led_reg, last_led_next;
    logic              is_last;

    assign is_last = (count_reg == BIT_LAST);

    always_comb
    begin
        active_next   = active_reg;
        word_next     = word_reg;
        count_next    = count_reg;
        last_led_next = last_led_reg;
        if (load_in.load)
        begin
            active_next   = 1'b1;
            word_next     = load_in.word;
            count_next    = '0;
            last_led_next = load_in.last_led;
        end
        else if (active_reg && out_ready)
        begin
            word_next  = {word_reg[WORD_W-2:0], 1'b0};
            count_next = count_reg + 1'b1;
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            count_reg    <= '0;
            last_led_reg <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            count_reg    <= count_next;
            last_led_reg <= last_led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid   = active_reg;
    assign busy        = active_reg;
    assign code_byte   = word_reg[WORD_W-1] ? one_pattern : zero_pattern;
    assign last_of_led = is_last;
    assign frame_done  = is_last && last_led_reg;

endmodule

@@ rtl/core/palette_led_strip_encoder.sv @@
// Palette LED strip encoder: code store, sequencer, config registers, serializer.
// Set: read in SET_RD, write-back in SET_WR. Fill: one store byte per cycle.
// Send: store read in SEND_RD, serializer load in SEND_LD, then 24 bytes at
// one per cycle while out_ready is high; the next item is taken after the 24th.
// Reset: config and send position return to defaults, then a clearing pass
// zeroes all (LED_COUNT+3)/4 store bytes with in_ready held low.
module palette_led_strip_encoder
    import ple_pkg::*;
#(
    parameter int LED_COUNT = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [WORD_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [5:0]        led_index,
    input  logic [1:0]        color_code,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] code_byte,
    output logic              last_of_led,
    output logic              frame_done
);

    localparam int STORE_BYTES = (LED_COUNT + 3) / 4;
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PW = $clog2(LED_COUNT);
    localparam logic [AW-1:0] LAST_BYTE = AW'(STORE_BYTES - 1);
    localparam logic [PW-1:0] LAST_LED  = PW'(LED_COUNT - 1);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_SET_RD  = 3'd2;
    localparam logic [2:0] ST_SET_WR  = 3'd3;
    localparam logic [2:0] ST_FILL    = 3'd4;
    localparam logic [2:0] ST_SEND_RD = 3'd5;
    localparam logic [2:0] ST_SEND_LD = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [AW-1:0]     set_addr_reg, set_addr_next;
    logic [1:0]        set_slot_reg, set_slot_next;
    logic [1:0]        set_code_reg, set_code_next;
    logic [BYTE_W-1:0] fill_byte_reg, fill_byte_next;
    logic [PW-1:0]     pos_reg, pos_next;

    logic [BYTE_W-1:0] one_reg;
    logic [BYTE_W-1:0] zero_reg;
    logic [WORD_W-1:0] palette_reg [4];

    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [BYTE_W-1:0] wr_data, rd_data;
    logic [BYTE_W-1:0] shifted_byte;
    logic [1:0]        send_code;
    logic              in_fire, set_in_range, ser_busy;
    ser_load_t         ser_load;

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == ST_IDLE) && !ser_busy;
    assign in_fire      = in_valid && in_ready;
    assign set_in_range = (32'(led_index) < 32'(LED_COUNT));
    assign shifted_byte = rd_data >> {pos_reg[1:0], 1'b0};
    assign send_code    = shifted_byte[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_reg        <= '0;
            zero_reg       <= '0;
            palette_reg[0] <= PALETTE_0_RST;
            palette_reg[1] <= PALETTE_1_RST;
            palette_reg[2] <= PALETTE_2_RST;
            palette_reg[3] <= PALETTE_3_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ONE_PATTERN:  one_reg        <= cfg_data[BYTE_W-1:0];
                CFG_ZERO_PATTERN: zero_reg       <= cfg_data[BYTE_W-1:0];
                CFG_PALETTE_0:    palette_reg[0] <= cfg_data;
                CFG_PALETTE_1:    palette_reg[1] <= cfg_data;
                CFG_PALETTE_2:    palette_reg[2] <= cfg_data;
                CFG_PALETTE_3:    palette_reg[3] <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        set_addr_next  = set_addr_reg;
        set_slot_next  = set_slot_reg;
        set_code_next  = set_code_reg;
        fill_byte_next = fill_byte_reg;
        pos_next       = pos_reg;
        rd_en          = 1'b0;
        rd_addr        = set_addr_reg;
        wr_en          = 1'b0;
        wr_addr        = sweep_reg;
        wr_data        = fill_byte_reg;
        ser_load.load     = 1'b0;
        ser_load.word     = palette_reg[send_code];
        ser_load.last_led = (pos_reg == LAST_LED);
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_BYTE)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (func)
                        FUNC_SET:
                        begin
                            if (set_in_range)
                            begin
                                set_addr_next = AW'(led_index >> 2);
                                set_slot_next = led_index[1:0];
                                set_code_next = color_code;
                                state_next    = ST_SET_RD;
                            end
                        end
                        FUNC_FILL:
                        begin
                            fill_byte_next = {4{color_code}};
                            sweep_next     = '0;
                            state_next     = ST_FILL;
                        end
                        FUNC_SEND:
                        begin
                            state_next = ST_SEND_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SET_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = set_addr_reg;
                state_next = ST_SET_WR;
            end
            ST_SET_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = set_addr_reg;
                wr_data = (rd_data & ~(CODE_MASK << {set_slot_reg, 1'b0}))
                        | (BYTE_W'(set_code_reg) << {set_slot_reg, 1'b0});
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
                wr_data = fill_byte_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_BYTE)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_SEND_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = AW'(pos_reg >> 2);
                state_next = ST_SEND_LD;
            end
            ST_SEND_LD:
            begin
                ser_load.load = 1'b1;
                pos_next      = (pos_reg == LAST_LED) ? '0 : pos_reg + 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sweep_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_addr_reg  <= set_addr_next;
        set_slot_reg  <= set_slot_next;
        set_code_reg  <= set_code_next;
        fill_byte_reg <= fill_byte_next;
    end

    ple_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    ple_serializer u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_in      (ser_load),
        .one_pattern  (one_reg),
        .zero_pattern (zero_reg),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .code_byte    (code_byte),
        .last_of_led  (last_of_led),
        .frame_done   (frame_done),
        .busy         (ser_busy)
    );

endmodule

@@ rtl/core/ple_checker.sv @@
// Port-level assertion checker for the palette LED strip encoder, bound to the top level.
`include "palette_led_strip_encoder_macros.svh"

module ple_checker
    import ple_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [1:0]        func,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] code_byte,
    input logic              last_of_led,
    input logic              frame_done
);

    `PLE_ASSERT_NOW(a_frame_on_led_end, out_valid && frame_done, last_of_led, "frame_done without last_of_led")
    `PLE_ASSERT_NOW(a_no_input_while_sending, out_valid, !in_ready, "input ready during send")
    `PLE_ASSERT_NEXT(a_send_blocks_input, in_valid && in_ready && func == FUNC_SEND, !in_ready, "input ready right after send")
    `PLE_ASSERT_NEXT(a_output_holds, out_valid && !out_ready, out_valid && $stable(code_byte), "stalled output changed")

endmodule

bind palette_led_strip_encoder ple_checker u_ple_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_byte   (code_byte),
    .last_of_led (last_of_led),
    .frame_done  (frame_done)
);

@@ tb/tb.sv @@
// Self-checking testbench for the palette LED strip encoder with its own bit-level predictor.
`timescale 1ns / 100ps

module tb;
    import ple_pkg::*;

    localparam int STRIP_LEDS    = 64;
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              last_of_led;
        logic              frame_done;
    } spi_byte_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [WORD_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        func;
    logic [5:0]        led_index;
    logic [1:0]        color_code;
    logic              out_valid;
    logic              out_ready;
    logic [BYTE_W-1:0] code_byte;
    logic              last_of_led;
    logic              frame_done;

    logic [BYTE_W-1:0] one_pattern;
    logic [BYTE_W-1:0] zero_pattern;
    logic [WORD_W-1:0] palette_word [4];
    logic [1:0]        led_code [STRIP_LEDS];
    int                send_pos;
    spi_byte_t         pending_bytes [$];
    spi_byte_t         want;

    int error_count;
    int cycle_count;
    bit no_gaps;
    int hold_request;

    palette_led_strip_encoder #(.LED_COUNT(STRIP_LEDS)) u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic apply_config(input logic [2:0] idx, input logic [WORD_W-1:0] data);
        case (idx)
            CFG_ONE_PATTERN:  one_pattern = data[BYTE_W-1:0];
            CFG_ZERO_PATTERN: zero_pattern = data[BYTE_W-1:0];
            CFG_PALETTE_0:    palette_word[0] = data;
            CFG_PALETTE_1:    palette_word[1] = data;
            CFG_PALETTE_2:    palette_word[2] = data;
            CFG_PALETTE_3:    palette_word[3] = data;
            default:          ;
        endcase
    endtask

    task automatic encode_led_item(input logic [1:0] f, input logic [5:0] idx,
                                   input logic [1:0] cc);
        logic [WORD_W-1:0] word;
        spi_byte_t         b;
        bit                last_led;
        int                i;
        case (f)
            FUNC_SET:  led_code[idx] = cc;
            FUNC_FILL: foreach (led_code[n]) led_code[n] = cc;
            FUNC_SEND:
            begin
                word = palette_word[led_code[send_pos]];
                last_led = (send_pos == STRIP_LEDS - 1);
                for (i = 0; i < WORD_W; i++)
                begin
                    b.code_byte = word[WORD_W-1-i] ? one_pattern : zero_pattern;
                    b.last_of_led = (i == WORD_W - 1);
                    b.frame_done = b.last_of_led && last_led;
                    pending_bytes.push_back(b);
                end
                send_pos = last_led ? 0 : send_pos + 1;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [1:0] f, input logic [5:0] idx, input logic [1:0] cc);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        led_index  <= idx;
        color_code <= cc;
        do @(posedge clk); while (!in_ready);
        encode_led_item(f, idx, cc);
    endtask

    task automatic send_random_item();
        int r;
        logic [1:0] f;
        r = $urandom_range(0, 99);
        if (r < 55)
            f = FUNC_SEND;
        else if (r < 85)
            f = FUNC_SET;
        else if (r < 92)
            f = FUNC_FILL;
        else
            f = FUNC_UNUSED;
        send_item(f, 6'($urandom), 2'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [WORD_W-1:0] data);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_config(idx, data);
    endtask

    task automatic end_config();
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    task automatic test_reset_palette();
        send_item(FUNC_SEND, 6'd0, 2'd0);
        wait_idle();
        write_reg(CFG_ONE_PATTERN, 24'h0000F8);
        write_reg(CFG_ZERO_PATTERN, 24'h0000C0);
        end_config();
        send_item(FUNC_SET, 6'd1, 2'd1);
        send_item(FUNC_SET, 6'd2, 2'd2);
        send_item(FUNC_SET, 6'd3, 2'd3);
        send_item(FUNC_SET, 6'd63, 2'd3);
        send_item(FUNC_SEND, 6'd63, 2'd3);
        send_item(FUNC_SEND, 6'd0, 2'd0);
        send_item(FUNC_SEND, 6'd21, 2'd1);
        send_item(FUNC_UNUSED, 6'd4, 2'd3);
        send_item(FUNC_FILL, 6'd42, 2'd2);
        send_item(FUNC_SEND, 6'd0, 2'd0);
        wait_idle();
    endtask

    task automatic test_palette_extremes();
        write_reg(CFG_PALETTE_0, 24'hFFFFFF);
        write_reg(CFG_PALETTE_1, 24'h000000);
        write_reg(CFG_PALETTE_2, 24'h800001);
        write_reg(CFG_PALETTE_3, 24'h5A5A5A);
        write_reg(CFG_ONE_PATTERN, 24'hFFFFFF);
        write_reg(CFG_ZERO_PATTERN, 24'hFFFF00);
        write_reg(CFG_SPARE_6, 24'hFFFFFF);
        write_reg(CFG_SPARE_7, 24'h123456);
        end_config();
        send_item(FUNC_SET, 6'd6, 2'd0);
        send_item(FUNC_SET, 6'd7, 2'd1);
        send_item(FUNC_SET, 6'd8, 2'd2);
        send_item(FUNC_SET, 6'd9, 2'd3);
        repeat (5) send_item(FUNC_SEND, 6'($urandom), 2'($urandom));
        wait_idle();
        write_reg(CFG_ONE_PATTERN, 24'h000000);
        write_reg(CFG_ZERO_PATTERN, 24'h0000FF);
        end_config();
        repeat (2) send_item(FUNC_SEND, 6'd0, 2'd0);
        wait_idle();
    endtask

    task automatic test_full_frame();
        write_reg(CFG_ONE_PATTERN, 24'h0000F0);
        write_reg(CFG_ZERO_PATTERN, 24'h0000C0);
        end_config();
        no_gaps = 1'b1;
        send_item(FUNC_FILL, 6'd0, 2'd3);
        send_item(FUNC_SET, 6'd0, 2'd1);
        send_item(FUNC_SET, 6'd63, 2'd2);
        repeat (STRIP_LEDS) send_item(FUNC_SEND, 6'($urandom), 2'($urandom));
        no_gaps = 1'b0;
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_request = LONG_HOLD;
        repeat (12) send_item(FUNC_SEND, 6'($urandom), 2'($urandom));
        send_item(FUNC_SET, 6'($urandom), 2'($urandom));
        wait_idle();
        repeat (10) send_random_item();
        wait_idle();
    endtask

    task automatic test_random_settings();
        int phase;
        int r;
        for (phase = 0; phase < 4; phase++)
        begin
            write_reg(CFG_ONE_PATTERN, pick_value());
            write_reg(CFG_ZERO_PATTERN, pick_value());
            write_reg(CFG_PALETTE_0, pick_value());
            write_reg(CFG_PALETTE_1, pick_value());
            write_reg(CFG_PALETTE_2, pick_value());
            write_reg(CFG_PALETTE_3, pick_value());
            r = $urandom_range(0, 1);
            write_reg(r ? CFG_SPARE_7 : CFG_SPARE_6, pick_value());
            end_config();
            repeat (45) send_random_item();
            wait_idle();
        end
    endtask

    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            else
                stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("unexpected code byte %02h", code_byte));
            else
            begin
                want = pending_bytes.pop_front();
                if (code_byte !== want.code_byte)
                    report_mismatch($sformatf("code_byte %02h, want %02h",
                                              code_byte, want.code_byte));
                if (last_of_led !== want.last_of_led)
                    report_mismatch($sformatf("last_of_led %b, want %b",
                                              last_of_led, want.last_of_led));
                if (frame_done !== want.frame_done)
                    report_mismatch($sformatf("frame_done %b, want %b",
                                              frame_done, want.frame_done));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL palette_led_strip_encoder");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_ONE_PATTERN;
        cfg_data     = '0;
        in_valid     = 1'b0;
        func         = FUNC_SET;
        led_index    = '0;
        color_code   = '0;
        error_count  = 0;
        cycle_count  = 0;
        no_gaps      = 1'b0;
        hold_request = 0;

        one_pattern     = '0;
        zero_pattern    = '0;
        palette_word[0] = PALETTE_0_RST;
        palette_word[1] = PALETTE_1_RST;
        palette_word[2] = PALETTE_2_RST;
        palette_word[3] = PALETTE_3_RST;
        foreach (led_code[n]) led_code[n] = 2'd0;
        send_pos = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_palette();
        test_palette_extremes();
        test_full_frame();
        test_backpressure();
        test_random_settings();
        wait_idle();

        if (error_count == 0)
            $display("PASS palette_led_strip_encoder");
        else
            $display("FAIL palette_led_strip_encoder");
        $finish;
    end

endmodule
